>>> hw/rtl/pfcd_pkg.sv
// ----------------------------------------------------------------------------
// pfcd_pkg: shared types and constants of the parallel flash command device
// Bus protocol codes, default geometry, config register indexes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pfcd_pkg;

    // Default geometry (powers of two)
    localparam int P_BANK_BYTES = 65536;
    localparam int P_NUM_BANKS  = 2;
    localparam int SECTOR_BYTES = 4096;

    // Unlock sequence, bank select and ID read addresses
    localparam logic [15:0] ADDR_UNLOCK1 = 16'h5555;
    localparam logic [15:0] ADDR_UNLOCK2 = 16'h2AAA;
    localparam logic [15:0] ADDR_BANK    = 16'h0000;
    localparam logic [15:0] ADDR_MFR_ID  = 16'h0000;
    localparam logic [15:0] ADDR_DEV_ID  = 16'h0001;
    localparam logic [7:0]  DATA_UNLOCK1 = 8'hAA;
    localparam logic [7:0]  DATA_UNLOCK2 = 8'h55;

    // Command bytes
    localparam logic [7:0] CMD_ID_ENTRY     = 8'h90;
    localparam logic [7:0] CMD_ID_EXIT      = 8'hF0;
    localparam logic [7:0] CMD_ERASE_ARM    = 8'h80;
    localparam logic [7:0] CMD_PROGRAM      = 8'hA0;
    localparam logic [7:0] CMD_BANK_SELECT  = 8'hB0;
    localparam logic [7:0] CMD_CHIP_ERASE   = 8'h10;
    localparam logic [7:0] CMD_SECTOR_ERASE = 8'h30;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // Bus operation
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Config register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MFR_ID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ID     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_BANKS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_OPS = 2'd3;

    // Source of the result byte
    typedef enum logic [1:0] {
        SRC_MEM  = 2'd0,
        SRC_ID   = 2'd1,
        SRC_ZERO = 2'd2
    } t_res_src;

    // Controller -> datapath
    typedef struct packed {
        logic       capture;
        logic       mem_rd;
        logic       prog_wr;
        logic       chip_load;
        logic       sector_load;
        logic       sweep_step;
        logic       bank;
        logic       res_load;
        t_res_src   res_src;
        logic [7:0] res_id;
        logic       res_err;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic        op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        sweep_last;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hw/rtl/pfcd_in_if.sv
// ----------------------------------------------------------------------------
// pfcd_in_if: bus access channel
// One beat is one read or write access on the flash bus.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfcd_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, output operation, output address, output write_data,
                    input ready);
    modport sink (input valid, input operation, input address, input write_data,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pfcd_out_if.sv
// ----------------------------------------------------------------------------
// pfcd_out_if: access result channel
// One beat per bus access: read byte and command error flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfcd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       command_error;

    modport source (output valid, output read_data, output command_error, input ready);
    modport sink (input valid, input read_data, input command_error, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/parallel_flash_command_device.sv
// ----------------------------------------------------------------------------
// parallel_flash_command_device: bus-level model of a byte-wide flash chip
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// Each beat on i_in is one bus access and yields one beat on o_out. The array
// is a single-port byte-wide memory, so every access is sequenced through it:
// a read or a plain command write is decoded and then answered, a byte
// program reads the byte, then ANDs it with the write data and writes it back,
// a sector erase writes min(SECTOR_BYTES, BANK_BYTES) bytes and a chip erase
// NUM_BANKS * BANK_BYTES bytes, one byte written per cycle. After reset a
// clearing pass fills the whole array with 0xFF, NUM_BANKS * BANK_BYTES
// bytes (131072 by default), before the first access is accepted;
// configuration writes are taken at any time. A finished result waits in an
// output register while the next access is decoded. BANK_BYTES must be a
// power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module parallel_flash_command_device
    import pfcd_pkg::*;
#(
    parameter int BANK_BYTES = P_BANK_BYTES,
    parameter int NUM_BANKS  = P_NUM_BANKS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    pfcd_in_if.sink                    i_in,
    pfcd_out_if.source                 o_out
);

    logic [7:0] r_mfr_id;
    logic [7:0] r_dev_id;
    logic       r_two_banks;
    logic       r_sector_ops;

    t_dp_cmd    cmd;
    t_dp_stat   stat;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] read_data;
    logic       command_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mfr_id     <= '0;
            r_dev_id     <= '0;
            r_two_banks  <= 1'b0;
            r_sector_ops <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MFR_ID:     r_mfr_id     <= i_cfg_wdata;
                CFG_DEV_ID:     r_dev_id     <= i_cfg_wdata;
                CFG_TWO_BANKS:  r_two_banks  <= i_cfg_wdata[0];
                CFG_SECTOR_OPS: r_sector_ops <= i_cfg_wdata[0];
                default:        r_mfr_id     <= r_mfr_id;
            endcase
        end
    end

    pfcd_controller #(
        .NUM_BANKS (NUM_BANKS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .o_in_ready   (in_ready),
        .o_out_valid  (out_valid),
        .i_out_ready  (o_out.ready),
        .i_mfr_id     (r_mfr_id),
        .i_dev_id     (r_dev_id),
        .i_two_banks  (r_two_banks),
        .i_sector_ops (r_sector_ops),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    pfcd_datapath #(
        .BANK_BYTES (BANK_BYTES),
        .NUM_BANKS  (NUM_BANKS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_operation     (i_in.operation),
        .i_address       (i_in.address),
        .i_write_data    (i_in.write_data),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_read_data     (read_data),
        .o_command_error (command_error)
    );

    assign i_in.ready          = in_ready;
    assign o_out.valid         = out_valid;
    assign o_out.read_data     = read_data;
    assign o_out.command_error = command_error;

endmodule

`default_nettype wire

>>> hw/rtl/pfcd_datapath.sv
// ----------------------------------------------------------------------------
// pfcd_datapath: flash array and access registers
// Holds the byte array, the captured access, the erase sweep counters and
// the result register. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module pfcd_datapath
    import pfcd_pkg::*;
#(
    parameter int BANK_BYTES = P_BANK_BYTES,
    parameter int NUM_BANKS  = P_NUM_BANKS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_operation,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_write_data,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_stat         o_stat,
    output logic [7:0]       o_read_data,
    output logic             o_command_error
);

    localparam int MEM_DEPTH = NUM_BANKS * BANK_BYTES;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int BANK_AW   = $clog2(BANK_BYTES);
    localparam int SEC_LEN   = (SECTOR_BYTES < BANK_BYTES) ? SECTOR_BYTES : BANK_BYTES;
    localparam logic [BANK_AW-1:0] SEC_MASK = BANK_AW'(SEC_LEN - 1);

    logic [7:0]        r_mem [MEM_DEPTH];
    logic [7:0]        r_rdata;
    logic              r_op;
    logic [15:0]       r_addr;
    logic [7:0]        r_data;
    logic [MEM_AW-1:0] r_sweep_addr;
    logic [MEM_AW:0]   r_sweep_left;
    logic [7:0]        r_read_data;
    logic              r_cmd_err;

    logic [BANK_AW-1:0] offset;
    logic [MEM_AW-1:0]  loc;
    logic [MEM_AW-1:0]  sec_start;
    logic               mem_we;
    logic [MEM_AW-1:0]  mem_waddr;
    logic [7:0]         mem_wdata;

    assign offset    = r_addr[BANK_AW-1:0];
    assign loc       = MEM_AW'({i_cmd.bank, offset});
    assign sec_start = MEM_AW'({i_cmd.bank, offset & ~SEC_MASK});

    assign mem_we    = i_cmd.sweep_step | i_cmd.prog_wr;
    assign mem_waddr = i_cmd.sweep_step ? r_sweep_addr : loc;
    assign mem_wdata = i_cmd.sweep_step ? ERASED_BYTE : (r_rdata & r_data);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[loc];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_operation;
            r_addr <= i_address;
            r_data <= i_write_data;
        end
    end

    // Sweep counters start the clearing pass straight out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr <= '0;
            r_sweep_left <= (MEM_AW+1)'(MEM_DEPTH);
        end else if (i_cmd.chip_load) begin
            r_sweep_addr <= '0;
            r_sweep_left <= (MEM_AW+1)'(MEM_DEPTH);
        end else if (i_cmd.sector_load) begin
            r_sweep_addr <= sec_start;
            r_sweep_left <= (MEM_AW+1)'(SEC_LEN);
        end else if (i_cmd.sweep_step) begin
            r_sweep_addr <= r_sweep_addr + 1'b1;
            r_sweep_left <= r_sweep_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            unique case (i_cmd.res_src)
                SRC_MEM: r_read_data <= r_rdata;
                SRC_ID:  r_read_data <= i_cmd.res_id;
                default: r_read_data <= '0;
            endcase
            r_cmd_err <= i_cmd.res_err;
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.addr       = r_addr;
    assign o_stat.data       = r_data;
    assign o_stat.sweep_last = (r_sweep_left == (MEM_AW+1)'(1));

    assign o_read_data     = r_read_data;
    assign o_command_error = r_cmd_err;

endmodule

`default_nettype wire

>>> hw/rtl/pfcd_controller.sv
// ----------------------------------------------------------------------------
// pfcd_controller: access sequencer and command decoder
// Runs the handshake state machine, tracks the unlock/command sequence,
// ID mode, erase arming and bank, and steers the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module pfcd_controller
    import pfcd_pkg::*;
#(
    parameter int NUM_BANKS = P_NUM_BANKS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [7:0] i_mfr_id,
    input  wire logic [7:0] i_dev_id,
    input  wire logic       i_two_banks,
    input  wire logic       i_sector_ops,
    input  wire t_dp_stat   i_stat,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_EXEC  = 7'b0000100,
        S_PROG  = 7'b0001000,
        S_ERASE = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_WAIT  = 7'b1000000
    } t_state;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_AA   = 5'b00010,
        PH_55   = 5'b00100,
        PH_PROG = 5'b01000,
        PH_BANK = 5'b10000
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_id_mode, n_id_mode;
    logic   r_armed, n_armed;
    logic   r_bank, n_bank;
    logic   r_err, n_err;
    logic   r_out_valid, n_out_valid;

    logic   banked;
    logic   out_free;
    logic   fail;
    logic   do_prog, do_chip, do_sector;

    assign banked   = (NUM_BANKS > 1) && i_two_banks;
    assign out_free = !r_out_valid || i_out_ready;

    // Sequence decode of a captured write
    always_comb begin
        n_phase   = r_phase;
        n_id_mode = r_id_mode;
        n_armed   = r_armed;
        n_bank    = r_bank;
        fail      = 1'b0;
        do_prog   = 1'b0;
        do_chip   = 1'b0;
        do_sector = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_stat.addr == ADDR_UNLOCK1 && i_stat.data == DATA_UNLOCK1) begin
                    n_phase = PH_AA;
                end else begin
                    fail = r_armed;
                end
            end
            PH_AA: begin
                if (i_stat.addr == ADDR_UNLOCK2 && i_stat.data == DATA_UNLOCK2) begin
                    n_phase = PH_55;
                end else begin
                    fail = 1'b1;
                end
            end
            PH_55: begin
                n_phase = PH_IDLE;
                if (r_armed) begin
                    n_armed = 1'b0;
                    if (i_stat.data == CMD_CHIP_ERASE && i_stat.addr == ADDR_UNLOCK1) begin
                        do_chip = 1'b1;
                    end else if (i_stat.data == CMD_SECTOR_ERASE) begin
                        do_sector = i_sector_ops;
                    end else begin
                        fail = 1'b1;
                    end
                end else if (i_stat.addr != ADDR_UNLOCK1) begin
                    fail = 1'b1;
                end else begin
                    unique case (i_stat.data)
                        CMD_ID_ENTRY:    n_id_mode = 1'b1;
                        CMD_ID_EXIT:     n_id_mode = 1'b0;
                        CMD_ERASE_ARM:   n_armed = 1'b1;
                        CMD_PROGRAM:     if (i_sector_ops) n_phase = PH_PROG;
                        CMD_BANK_SELECT: if (banked) n_phase = PH_BANK;
                        default:         fail = 1'b1;
                    endcase
                end
            end
            PH_PROG: begin
                n_phase = PH_IDLE;
                do_prog = 1'b1;
            end
            PH_BANK: begin
                n_phase = PH_IDLE;
                if (i_stat.addr != ADDR_BANK) begin
                    fail = 1'b1;
                end else begin
                    n_bank = i_stat.data[0];
                end
            end
            default: fail = 1'b1;
        endcase
        // Broken sequence: drop back to idle, disarm, keep ID mode
        if (fail) begin
            n_phase = PH_IDLE;
            n_armed = 1'b0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.bank  = banked ? r_bank : 1'b0;
        o_cmd.res_src = SRC_ZERO;
        o_in_ready  = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = 1'b1;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_err = 1'b0;
                if (i_stat.op == OP_READ) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    n_err = fail;
                    if (do_prog) begin
                        o_cmd.mem_rd = 1'b1;
                        n_state      = S_PROG;
                    end else if (do_chip || do_sector) begin
                        o_cmd.chip_load   = do_chip;
                        o_cmd.sector_load = do_sector;
                        n_state           = S_ERASE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_PROG: begin
                o_cmd.prog_wr = 1'b1;
                n_state       = S_DONE;
            end
            S_ERASE: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE, S_WAIT: begin
                if (i_stat.op == OP_WRITE) begin
                    o_cmd.res_src = SRC_ZERO;
                end else if (r_id_mode && i_stat.addr == ADDR_MFR_ID) begin
                    o_cmd.res_src = SRC_ID;
                    o_cmd.res_id  = i_mfr_id;
                end else if (r_id_mode && i_stat.addr == ADDR_DEV_ID) begin
                    o_cmd.res_src = SRC_ID;
                    o_cmd.res_id  = i_dev_id;
                end else begin
                    o_cmd.res_src = SRC_MEM;
                end
                o_cmd.res_err = r_err;
                // Hold the result until the output register frees up
                if (out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_WAIT;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    logic seq_update;
    assign seq_update = (r_state == S_EXEC) && (i_stat.op == OP_WRITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_phase     <= PH_IDLE;
            r_id_mode   <= 1'b0;
            r_armed     <= 1'b0;
            r_bank      <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            if (seq_update) begin
                r_phase   <= n_phase;
                r_id_mode <= n_id_mode;
                r_armed   <= n_armed;
                r_bank    <= n_bank;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending beat");

    // Arming only survives through the unlock steps
    a_armed_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> (r_phase == PH_IDLE || r_phase == PH_AA || r_phase == PH_55))
        else $error("erase armed in a data phase");

    // An accepted beat is decoded in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted beat not decoded");

    // Reads never report a command error
    a_read_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.res_load && o_cmd.res_err) |-> (i_stat.op == OP_WRITE))
        else $error("command error on a read");

    // Only one memory access is steered at a time
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.mem_rd, o_cmd.prog_wr, o_cmd.sweep_step}) <= 1)
        else $error("conflicting memory accesses");

endmodule

`default_nettype wire
